@@ rtl/dibp_pkg.sv @@
package dibp_pkg;

    localparam int unsigned BYTE_BITS = 8;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_width;
    typedef logic [8:0] t_count;

    typedef struct packed {
        logic rd_en;
        logic upd_en;
        logic last;
    } t_map_ctl;

    typedef struct packed {
        t_byte code;
        logic  new_symbol;
        logic  overflow;
    } t_lookup;

    typedef struct packed {
        logic  byte_valid;
        t_byte packed_byte;
        logic  flush;
        t_byte flush_byte;
    } t_pack;

    function automatic t_width eff_width(input t_width bits);
        t_width w;
        if (bits < 4'd1) begin
            w = 4'd1;
        end else if (bits > 4'd8) begin
            w = 4'd8;
        end else begin
            w = bits;
        end
        return w;
    endfunction

endpackage

@@ rtl/dibp_symbol_map.sv @@
module dibp_symbol_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dibp_pkg::t_map_ctl i_ctl,
    input  dibp_pkg::t_byte   i_rd_addr,
    input  dibp_pkg::t_byte   i_s1_sym,
    input  dibp_pkg::t_width  i_width,
    output dibp_pkg::t_lookup o_lookup
);
    import dibp_pkg::*;

    logic   [255:0] r_seen;
    t_byte          r_mem [256];
    t_byte          r_map_q;
    logic           r_fwd;
    t_byte          r_fwd_code;
    t_count         r_count;
    t_count         n_count;
    logic   [255:0] n_seen;
    logic           seen;
    logic           fits;
    t_byte          stored;
    t_lookup        lk;

    assign seen   = r_seen[i_s1_sym];
    assign fits   = r_count < (9'd1 << i_width);
    assign stored = r_fwd ? r_fwd_code : r_map_q;

    always_comb begin
        lk = '0;
        if (seen) begin
            lk.code = stored;
        end else if (fits) begin
            lk.code       = r_count[7:0];
            lk.new_symbol = 1'b1;
        end else begin
            lk.overflow = 1'b1;
        end
    end

    assign o_lookup = lk;

    always_comb begin
        n_seen  = r_seen;
        n_count = r_count;
        if (i_ctl.upd_en) begin
            if (i_ctl.last) begin
                n_seen  = '0;
                n_count = '0;
            end else if (lk.new_symbol) begin
                n_seen[i_s1_sym] = 1'b1;
                n_count          = r_count + 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_count <= '0;
            r_fwd   <= 1'b0;
        end else begin
            r_seen  <= n_seen;
            r_count <= n_count;
            if (i_ctl.rd_en) begin
                r_fwd <= i_ctl.upd_en && lk.new_symbol && (i_s1_sym == i_rd_addr);
            end
        end
    end

    // same-cycle write bypass
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_fwd_code <= r_count[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd_en && lk.new_symbol) begin
            r_mem[i_s1_sym] <= r_count[7:0];
        end
        if (i_ctl.rd_en) begin
            r_map_q <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ rtl/dibp_bit_packer.sv @@
module dibp_bit_packer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_upd_en,
    input  logic             i_last,
    input  dibp_pkg::t_byte  i_code,
    input  dibp_pkg::t_width i_width,
    output dibp_pkg::t_pack  o_pack
);
    import dibp_pkg::*;

    t_byte       r_acc;
    t_width      r_filled;
    t_byte       n_acc;
    t_width      n_filled;
    t_byte       mask;
    logic [15:0] v;
    logic [15:0] v_sh;
    t_width      total;
    t_width      rem;
    t_pack       pk;

    always_comb begin
        mask  = 8'hFF >> (4'd8 - i_width);
        v     = ({8'h00, r_acc} << i_width) | {8'h00, i_code & mask};
        total = r_filled + i_width;
        rem   = total - 4'd8;
        v_sh  = v >> rem;
        pk    = '0;
        if (total >= 4'd8) begin
            pk.byte_valid  = 1'b1;
            pk.packed_byte = v_sh[7:0];
            n_acc          = v[7:0] & (8'hFF >> (4'd8 - rem));
            n_filled       = rem;
        end else begin
            n_acc    = v[7:0];
            n_filled = total;
        end
        pk.flush      = i_last && (n_filled != 4'd0);
        pk.flush_byte = n_acc << (4'd8 - n_filled);
    end

    assign o_pack = pk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_filled <= '0;
        end else if (i_upd_en) begin
            if (i_last) begin
                r_acc    <= '0;
                r_filled <= '0;
            end else begin
                r_acc    <= n_acc;
                r_filled <= n_filled;
            end
        end
    end

endmodule

@@ rtl/dictionary_index_bit_packer.sv @@
// channel  direction  handshake                 payload
// input    in         i_in_valid / o_in_stall   i_symbol, i_last_symbol
// output   out        o_out_valid / i_out_stall o_code, o_new_symbol, o_overflow,
//                                               o_byte_valid, o_packed_byte, o_last_result
// config   in         i_cfg_wr_en               i_cfg_wr_data (code_bits)
//
// One word per cycle unless stalled; each word passes the input register, then the result register.
// A last word whose flush byte needs a second result is followed by that second result.
// Map lookup: one registered RAM read plus a bypass for the word just ahead.
// Synchronous active-low reset clears seen flags, counters and the packer at once.
// Output stall holds the result register and backs up through the input register.
module dictionary_index_bit_packer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [3:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_symbol,
    input  logic       i_last_symbol,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_code,
    output logic       o_new_symbol,
    output logic       o_overflow,
    output logic       o_byte_valid,
    output logic [7:0] o_packed_byte,
    output logic       o_last_result
);
    import dibp_pkg::*;

    t_width   r_code_bits;
    t_width   width;
    logic     r_s1_vld;
    t_byte    r_s1_sym;
    logic     r_s1_last;
    logic     r_out_vld;
    t_byte    r_code;
    logic     r_new;
    logic     r_ovf;
    logic     r_bv;
    t_byte    r_pb;
    logic     r_last;
    logic     r_pend;
    t_byte    r_pend_byte;
    logic     out_free;
    logic     s1_move;
    logic     in_acc;
    t_map_ctl ctl;
    t_lookup  lk;
    t_pack    pk;

    assign width    = eff_width(r_code_bits);
    assign out_free = !r_out_vld || !i_out_stall;
    assign s1_move  = r_s1_vld && out_free && !r_pend;
    assign o_in_stall = r_s1_vld && !s1_move;
    assign in_acc   = i_in_valid && !o_in_stall;

    assign ctl.rd_en  = in_acc;
    assign ctl.upd_en = s1_move;
    assign ctl.last   = r_s1_last;

    dibp_symbol_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_rd_addr (i_symbol),
        .i_s1_sym  (r_s1_sym),
        .i_width   (width),
        .o_lookup  (lk)
    );

    dibp_bit_packer u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd_en (s1_move),
        .i_last   (r_s1_last),
        .i_code   (lk.code),
        .i_width  (width),
        .o_pack   (pk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits <= 4'd1;
            r_s1_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_code_bits <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (out_free) begin
                if (r_pend) begin
                    r_out_vld <= 1'b1;
                    r_pend    <= 1'b0;
                end else if (r_s1_vld) begin
                    r_out_vld <= 1'b1;
                    r_pend    <= pk.flush && pk.byte_valid;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sym  <= i_symbol;
            r_s1_last <= i_last_symbol;
        end
        if (out_free) begin
            if (r_pend) begin
                r_code <= '0;
                r_new  <= 1'b0;
                r_ovf  <= 1'b0;
                r_bv   <= 1'b1;
                r_pb   <= r_pend_byte;
                r_last <= 1'b1;
            end else if (r_s1_vld) begin
                r_code      <= lk.code;
                r_new       <= lk.new_symbol;
                r_ovf       <= lk.overflow;
                r_pend_byte <= pk.flush_byte;
                if (pk.flush && !pk.byte_valid) begin
                    r_bv   <= 1'b1;
                    r_pb   <= pk.flush_byte;
                    r_last <= 1'b1;
                end else begin
                    r_bv   <= pk.byte_valid;
                    r_pb   <= pk.packed_byte;
                    r_last <= r_s1_last && !pk.flush;
                end
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_code        = r_code;
    assign o_new_symbol  = r_new;
    assign o_overflow    = r_ovf;
    assign o_byte_valid  = r_bv;
    assign o_packed_byte = r_pb;
    assign o_last_result = r_last;

`ifndef NO_ASSERTIONS
    a_pend_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_out_vld)
        else $error("flush pending without a result in the output register");

    a_pend_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_last_result)
        else $error("first of two results marked last");

    a_new_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_new_symbol && o_overflow))
        else $error("new symbol and overflow together");

    a_empty_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_packed_byte == 8'h00))
        else $error("packed byte nonzero without byte valid");
`endif

endmodule
